>>> sv/sskg_pkg.sv
// Shared types and constants for the small-state keystream generator.
// Command codes, datapath operation codes and controller/datapath structs.
// No dependencies.
package sskg_pkg;

    localparam int POOL_WORDS_DEF = 16;

    localparam logic [31:0] GOLDEN = 32'h9e3779b9;

    // command field of an input beat
    localparam logic [1:0] CMD_NEXT  = 2'd0;
    localparam logic [1:0] CMD_RESET = 2'd1;
    localparam logic [1:0] CMD_SEED  = 2'd2;
    localparam logic [1:0] CMD_FIN   = 2'd3;

    typedef logic [3:0] op_t;

    localparam op_t OP_NONE      = 4'd0;
    localparam op_t OP_CLEAR     = 4'd1;
    localparam op_t OP_SEED_RD   = 4'd2;
    localparam op_t OP_SEED_WR   = 4'd3;
    localparam op_t OP_FIN_START = 4'd4;
    localparam op_t OP_FIN_RD    = 4'd5;
    localparam op_t OP_FIN_ADD   = 4'd6;
    localparam op_t OP_REF_RD    = 4'd7;
    localparam op_t OP_REF_E     = 4'd8;
    localparam op_t OP_REF_D     = 4'd9;
    localparam op_t OP_OUT_RD    = 4'd10;
    localparam op_t OP_OUT_LOAD  = 4'd11;
    localparam op_t OP_DISCARD   = 4'd12;

    typedef struct packed {
        logic take;   // input beat accepted this cycle
        op_t  op;
    } dp_cmd_t;

    typedef struct packed {
        logic ri_last;      // read index at last buffer entry
        logic seed_full;    // seed byte position saturated
        logic fin_last;     // last pool word of seed finish
        logic ref_last;     // last refill step
        logic rounds_zero;  // no discards left
        logic out_free;     // output register can take a word
    } dp_sts_t;

endpackage

>>> sv/sskg_dp.sv
// Datapath of the keystream generator: pool and output buffer memories,
// mixing words, counters and the output register.
// Depends on sskg_pkg; driven by sskg_ctrl through dp_cmd_t.
module sskg_dp #(
    parameter int POOL_WORDS = sskg_pkg::POOL_WORDS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sskg_pkg::dp_cmd_t cmd,
    output sskg_pkg::dp_sts_t sts,
    input  logic [7:0]        seed_byte,
    input  logic [15:0]       rounds,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [31:0]       out_word
);
    import sskg_pkg::*;

    // POOL_WORDS is a power of two
    localparam int IDX_W = $clog2(POOL_WORDS);
    localparam int SC_W  = $clog2(4 * POOL_WORDS + 1);
    localparam logic [SC_W-1:0]  SEED_MAX = SC_W'(4 * POOL_WORDS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POOL_WORDS - 1);
    localparam logic [IDX_W-1:0] FIN_LAST = IDX_W'(3);

    logic [31:0] pool_mem [POOL_WORDS];
    logic [31:0] out_mem  [POOL_WORDS];
    logic [POOL_WORDS-1:0] pool_vld_reg, out_vld_reg;

    logic [31:0] cnt_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] pi_reg, rda_reg, rdb_reg, rdo_reg, od_reg;
    logic        rda_vld_reg, rdb_vld_reg, rdo_vld_reg, ov_reg;
    logic [IDX_W-1:0] ri_reg, idx_reg;
    logic [SC_W-1:0]  sc_reg;
    logic [15:0]      rcnt_reg;
    logic [7:0]       byte_reg;

    logic [31:0] pa, pb, po, merged, b_xor_c;
    logic [IDX_W-1:0] sel, seed_w, pool_ra, pool_wa;
    logic [4:0]  sh;
    logic        pool_we, pool_re;
    logic [31:0] pool_wd, step_d;

    // unwritten entries read as the golden constant
    assign pa = rda_vld_reg ? rda_reg : GOLDEN;
    assign pb = rdb_vld_reg ? rdb_reg : GOLDEN;
    assign po = rdo_vld_reg ? rdo_reg : GOLDEN;

    assign sel     = d_reg[IDX_W-1:0];
    assign seed_w  = sc_reg[2 +: IDX_W];
    assign sh      = {sc_reg[1:0], 3'b000};
    assign merged  = (pa & ~(32'h0000_00ff << sh)) | ({24'd0, byte_reg} << sh);
    assign b_xor_c = b_reg ^ c_reg;
    assign step_d  = e_reg + pi_reg;

    always_comb
    begin
        pool_ra = sel;
        pool_re = 1'b0;
        unique case (cmd.op)
            OP_SEED_RD:
            begin
                pool_ra = seed_w;
                pool_re = 1'b1;
            end
            OP_FIN_RD:
            begin
                pool_ra = idx_reg;
                pool_re = 1'b1;
            end
            OP_REF_RD:
            begin
                pool_ra = sel;
                pool_re = 1'b1;
            end
            default:
            begin
                pool_ra = sel;
                pool_re = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        pool_we = 1'b0;
        pool_wa = sel;
        pool_wd = b_xor_c;
        if (cmd.op == OP_SEED_WR)
        begin
            pool_we = 1'b1;
            pool_wa = seed_w;
            pool_wd = merged;
        end
        else if (cmd.op == OP_REF_E)
        begin
            pool_we = 1'b1;
        end
    end

    // memories and read registers
    always_ff @(posedge clk)
    begin
        if (pool_we)
        begin
            pool_mem[pool_wa] <= pool_wd;
        end
        if (pool_re)
        begin
            rda_reg     <= pool_mem[pool_ra];
            rda_vld_reg <= pool_vld_reg[pool_ra];
        end
        if (cmd.op == OP_REF_RD)
        begin
            rdb_reg     <= pool_mem[idx_reg];
            rdb_vld_reg <= pool_vld_reg[idx_reg];
        end
        if (cmd.op == OP_REF_D)
        begin
            out_mem[idx_reg] <= step_d;
        end
        if (cmd.op == OP_OUT_RD)
        begin
            rdo_reg     <= out_mem[ri_reg];
            rdo_vld_reg <= out_vld_reg[ri_reg];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            byte_reg <= seed_byte;
        end
        if (cmd.op == OP_REF_E)
        begin
            // pool[i] is read after pool[sel] was rewritten
            pi_reg <= (sel == idx_reg) ? b_xor_c : pb;
        end
        if (cmd.op == OP_OUT_LOAD)
        begin
            od_reg <= po;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_vld_reg <= '0;
            out_vld_reg  <= '0;
        end
        else if (cmd.op == OP_CLEAR)
        begin
            pool_vld_reg <= '0;
            out_vld_reg  <= '0;
        end
        else
        begin
            if (pool_we)
            begin
                pool_vld_reg[pool_wa] <= 1'b1;
            end
            if (cmd.op == OP_REF_D)
            begin
                out_vld_reg[idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= GOLDEN;
            b_reg    <= GOLDEN;
            c_reg    <= GOLDEN;
            d_reg    <= GOLDEN;
            e_reg    <= GOLDEN;
            ri_reg   <= '0;
            idx_reg  <= '0;
            sc_reg   <= '0;
            rcnt_reg <= '0;
        end
        else
        begin
            unique case (cmd.op)
                OP_CLEAR:
                begin
                    cnt_reg <= GOLDEN;
                    b_reg   <= GOLDEN;
                    c_reg   <= GOLDEN;
                    d_reg   <= GOLDEN;
                    e_reg   <= GOLDEN;
                    ri_reg  <= '0;
                    idx_reg <= '0;
                    sc_reg  <= '0;
                end
                OP_SEED_WR:
                begin
                    sc_reg <= sc_reg + 1'b1;
                end
                OP_FIN_START:
                begin
                    rcnt_reg <= rounds;
                    idx_reg  <= '0;
                end
                OP_FIN_ADD:
                begin
                    unique case (idx_reg[1:0])
                        2'd0: d_reg   <= d_reg + pa;
                        2'd1: c_reg   <= c_reg + pa;
                        2'd2: b_reg   <= b_reg + pa;
                        2'd3: cnt_reg <= cnt_reg + pa;
                    endcase
                    idx_reg <= (idx_reg == FIN_LAST) ? '0 : idx_reg + 1'b1;
                end
                OP_REF_E:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    e_reg   <= pa + cnt_reg + 32'd1;
                    b_reg   <= c_reg - d_reg;
                end
                OP_REF_D:
                begin
                    c_reg   <= d_reg + e_reg;
                    d_reg   <= step_d;
                    idx_reg <= idx_reg + 1'b1;
                end
                OP_OUT_RD:
                begin
                    ri_reg <= ri_reg + 1'b1;
                end
                OP_DISCARD:
                begin
                    ri_reg   <= ri_reg + 1'b1;
                    rcnt_reg <= rcnt_reg - 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (cmd.op == OP_OUT_LOAD)
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    assign out_valid = ov_reg;
    assign out_word  = od_reg;

    assign sts.ri_last     = (ri_reg == IDX_LAST);
    assign sts.seed_full   = (sc_reg == SEED_MAX);
    assign sts.fin_last    = (idx_reg == FIN_LAST);
    assign sts.ref_last    = (idx_reg == IDX_LAST);
    assign sts.rounds_zero = (rcnt_reg == 16'd0);
    assign sts.out_free    = !ov_reg || out_ready;

endmodule

>>> sv/sskg_ctrl.sv
// Controller state machine of the keystream generator.
// Decodes input beats and sequences refill, seeding and discard steps.
// Depends on sskg_pkg; drives sskg_dp through dp_cmd_t.
module sskg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        command,
    input  sskg_pkg::dp_sts_t sts,
    output sskg_pkg::dp_cmd_t cmd
);
    import sskg_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SEED_WR = 4'd1;
    localparam logic [3:0] S_FIN_RD  = 4'd2;
    localparam logic [3:0] S_FIN_ADD = 4'd3;
    localparam logic [3:0] S_REF_RD  = 4'd4;
    localparam logic [3:0] S_REF_E   = 4'd5;
    localparam logic [3:0] S_REF_D   = 4'd6;
    localparam logic [3:0] S_DISC    = 4'd7;
    localparam logic [3:0] S_NEXT_LD = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       wrap_reg, wrap_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        wrap_next  = wrap_reg;
        cmd.take   = 1'b0;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    unique case (command)
                        CMD_NEXT:
                        begin
                            cmd.op     = OP_OUT_RD;
                            wrap_next  = sts.ri_last;
                            state_next = S_NEXT_LD;
                        end
                        CMD_RESET:
                        begin
                            cmd.op = OP_CLEAR;
                        end
                        CMD_SEED:
                        begin
                            cmd.op = OP_SEED_RD;
                            if (!sts.seed_full)
                            begin
                                state_next = S_SEED_WR;
                            end
                        end
                        CMD_FIN:
                        begin
                            cmd.op     = OP_FIN_START;
                            state_next = S_FIN_RD;
                        end
                    endcase
                end
            end
            S_SEED_WR:
            begin
                cmd.op     = OP_SEED_WR;
                state_next = S_IDLE;
            end
            S_FIN_RD:
            begin
                cmd.op     = OP_FIN_RD;
                state_next = S_FIN_ADD;
            end
            S_FIN_ADD:
            begin
                cmd.op     = OP_FIN_ADD;
                state_next = sts.fin_last ? S_REF_RD : S_FIN_RD;
            end
            S_REF_RD:
            begin
                cmd.op     = OP_REF_RD;
                state_next = S_REF_E;
            end
            S_REF_E:
            begin
                cmd.op     = OP_REF_E;
                state_next = S_REF_D;
            end
            S_REF_D:
            begin
                cmd.op     = OP_REF_D;
                state_next = sts.ref_last ? S_DISC : S_REF_RD;
            end
            S_DISC:
            begin
                // also the exit of every refill; the count is zero outside seed finish
                if (sts.rounds_zero)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op = OP_DISCARD;
                    if (sts.ri_last)
                    begin
                        state_next = S_REF_RD;
                    end
                end
            end
            S_NEXT_LD:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_OUT_LOAD;
                    state_next = wrap_reg ? S_REF_RD : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wrap_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wrap_reg  <= wrap_next;
        end
    end

endmodule

>>> sv/small_state_keystream_generator.sv
// Top level of the small-state keystream generator.
// Instantiates sskg_ctrl and sskg_dp; uses sskg_pkg.
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tuser: command; s_tdata: seed_byte, rounds
// m_       out  m_tvalid/m_tready  m_tdata: random_word
//
// Next word: buffer read, then output load, plus a refill after every
// POOL_WORDS-th word; a refill step reads pool words, mixes and rewrites one,
// then writes the output buffer. Seed byte: read-modify-write of one pool
// word, only a read once the pool is full; reset clears the state.
// Seed finish: adds pool words 0..3 to the mixing words, refills, then
// discards rounds words, refilling on wrap. rst_n clears valid bits at once: no sweep.
// s_tready is high only between commands; a next word waits while m_ is stalled.
module small_state_keystream_generator #(
    parameter int POOL_WORDS = sskg_pkg::POOL_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] seed_byte, [23:8] rounds
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] random_word
);
    import sskg_pkg::*;

    dp_cmd_t ctl_cmd;
    dp_sts_t dp_sts;

    sskg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .command  (s_tuser),
        .sts      (dp_sts),
        .cmd      (ctl_cmd)
    );

    sskg_dp #(
        .POOL_WORDS (POOL_WORDS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ctl_cmd),
        .sts       (dp_sts),
        .seed_byte (s_tdata[7:0]),
        .rounds    (s_tdata[23:8]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_word  (m_tdata)
    );

`ifndef SYNTHESIS
    a_ref_e_order: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_cmd.op == OP_REF_E) |-> ($past(ctl_cmd.op) == OP_REF_RD))
        else $error("refill mix step without preceding read");

    a_ref_d_order: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_cmd.op == OP_REF_D) |-> ($past(ctl_cmd.op) == OP_REF_E))
        else $error("refill write step out of order");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_cmd.op == OP_OUT_LOAD) |-> (!m_tvalid || m_tready))
        else $error("output register overwritten while held");

    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(ctl_cmd.op) == OP_OUT_LOAD))
        else $error("output beat raised without a load");
`endif

endmodule

>>> bench/tb_top.sv
// Testbench for small_state_keystream_generator: directed and random command streams,
// with every output beat checked against an in-bench model of the generator.
// Depends on sskg_pkg and the RTL top level small_state_keystream_generator.
module tb_top;
    import sskg_pkg::*;

    localparam int NW         = POOL_WORDS_DEF;
    localparam int SEL_BITS   = $clog2(NW);
    localparam int SEED_LIMIT = 4 * NW;
    localparam int MAX_CYCLES = 2_000_000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;    // [7:0] seed_byte, [23:8] rounds
    logic [1:0]  s_tuser  = CMD_NEXT; // [1:0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [31:0] random_word

    small_state_keystream_generator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    // generator state as predicted by the bench
    logic [31:0] gen_pool [NW];
    logic [31:0] gen_obuf [NW];
    logic [31:0] gen_cnt, gen_b, gen_c, gen_d, gen_e;
    int unsigned gen_ridx;
    int unsigned gen_seed_pos;

    logic [31:0] expected_words [$];
    logic [31:0] want_word;

    int  errors      = 0;
    int  cycles      = 0;
    int  n_beats     = 0;
    int  n_words     = 0;
    int  n_finish    = 0;
    int  n_dropped   = 0;
    int  n_discarded = 0;
    int  hold_len    = 0;
    bit  sender_gaps   = 1'b1;
    bit  receiver_gaps = 1'b1;

    function automatic void gen_clear();
        for (int i = 0; i < NW; i++)
        begin
            gen_pool[i] = GOLDEN;
            gen_obuf[i] = GOLDEN;
        end
        gen_cnt      = GOLDEN;
        gen_b        = GOLDEN;
        gen_c        = GOLDEN;
        gen_d        = GOLDEN;
        gen_e        = GOLDEN;
        gen_ridx     = 0;
        gen_seed_pos = 0;
    endfunction

    function automatic void gen_refill();
        int sel;
        for (int i = 0; i < NW; i++)
        begin
            sel = int'(gen_d[SEL_BITS-1:0]);
            gen_cnt = gen_cnt + 32'd1;
            gen_e = gen_pool[sel] + gen_cnt;
            gen_pool[sel] = gen_b ^ gen_c;
            gen_b = gen_c - gen_d;
            gen_c = gen_d + gen_e;
            // pool[i] is read after the write above, sel may equal i
            gen_d = gen_e + gen_pool[i];
            gen_obuf[i] = gen_d;
        end
    endfunction

    function automatic logic [31:0] gen_next_word();
        logic [31:0] w;
        w = gen_obuf[gen_ridx];
        gen_ridx++;
        if (gen_ridx >= NW)
        begin
            gen_refill();
            gen_ridx = 0;
        end
        return w;
    endfunction

    function automatic void gen_apply(input logic [1:0] cmd, input logic [7:0] sbyte,
                                      input logic [15:0] rounds);
        int w;
        int sh;
        case (cmd)
            CMD_NEXT:  expected_words.push_back(gen_next_word());
            CMD_RESET: gen_clear();
            CMD_SEED:
            begin
                if (gen_seed_pos < SEED_LIMIT)
                begin
                    w  = (gen_seed_pos >> 2) % NW;
                    sh = (gen_seed_pos % 4) * 8;
                    gen_pool[w][sh +: 8] = sbyte;
                    gen_seed_pos++;
                end
                else
                    n_dropped++;
            end
            default:
            begin
                gen_cnt = gen_cnt + gen_pool[3];
                gen_b   = gen_b + gen_pool[2];
                gen_c   = gen_c + gen_pool[1];
                gen_d   = gen_d + gen_pool[0];
                gen_refill();
                for (int i = 0; i < rounds; i++)
                    void'(gen_next_word());
                n_finish++;
                n_discarded += rounds;
            end
        endcase
    endfunction

    // one input beat; returns at the edge where it is taken
    task automatic send_beat(input logic [1:0] cmd, input logic [7:0] sbyte,
                             input logic [15:0] rounds);
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {rounds, sbyte};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        gen_apply(cmd, sbyte, rounds);
        n_beats++;
    endtask

    task automatic send_seeded_run(input int nbytes, input int rounds, input int nwords);
        for (int i = 0; i < nbytes; i++)
            send_beat(CMD_SEED, 8'($urandom), 16'($urandom));
        send_beat(CMD_FIN, 8'($urandom), 16'(rounds));
        for (int i = 0; i < nwords; i++)
            send_beat(CMD_NEXT, 8'($urandom), 16'($urandom));
    endtask

    // receiver: random stall bursts, and a long hold-off on request
    initial
    begin
        forever
        begin
            if (hold_len > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end
            else if (receiver_gaps && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("random_word: expected none, actual %h", m_tdata);
                errors++;
            end
            else
            begin
                want_word = expected_words.pop_front();
                if (m_tdata !== want_word)
                begin
                    $error("random_word: expected %h, actual %h", want_word, m_tdata);
                    errors++;
                end
                n_words++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == MAX_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, expected_words.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic test_directed();
        send_beat(CMD_NEXT, 8'hff, 16'hffff);   // data fields are don't-care on next
        send_beat(CMD_NEXT, 8'h00, 16'h0000);
        send_beat(CMD_RESET, 8'h5a, 16'h8001);
        send_beat(CMD_SEED, 8'h00, 16'hffff);   // zero key byte stored as any other
        send_beat(CMD_SEED, 8'hff, 16'h0000);
        send_beat(CMD_SEED, 8'h80, 16'h0000);
        send_beat(CMD_SEED, 8'h01, 16'h0000);
        send_beat(CMD_SEED, 8'h7e, 16'h0000);
        send_beat(CMD_FIN, 8'hff, 16'd0);       // nothing discarded
        send_beat(CMD_NEXT, 8'h00, 16'h0000);
        send_beat(CMD_NEXT, 8'h00, 16'h0000);
        send_beat(CMD_SEED, 8'hc3, 16'h0000);   // lands in the live pool
        send_beat(CMD_NEXT, 8'h00, 16'h0000);
        send_beat(CMD_FIN, 8'h00, 16'd1);
        send_beat(CMD_FIN, 8'h00, 16'hffff);    // longest discard run
        send_beat(CMD_NEXT, 8'h00, 16'h0000);
        send_beat(CMD_NEXT, 8'h00, 16'h0000);
        send_beat(CMD_RESET, 8'h00, 16'h0000);
        send_beat(CMD_NEXT, 8'h00, 16'h0000);
        send_beat(CMD_NEXT, 8'h00, 16'h0000);
    endtask

    task automatic test_seed_overflow();
        send_beat(CMD_RESET, 8'($urandom), 16'($urandom));
        // past 4*POOL_WORDS bytes the position saturates
        send_seeded_run(SEED_LIMIT + 8, $urandom_range(0, 20), 20);
    endtask

    task automatic test_output_stall();
        hold_len = 400;
        for (int i = 0; i < 40; i++)
            send_beat(CMD_NEXT, 8'($urandom), 16'($urandom));
    endtask

    task automatic test_random(input int nitems);
        int start;
        int pick;
        int nbytes;
        int rounds;
        logic [1:0] cmd;
        start = n_beats;
        while (n_beats - start < nitems)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                // noise: any command with random fields, FIN rounds kept to 0..64
                cmd = 2'($urandom);
                rounds = (cmd == CMD_FIN) ? $urandom_range(0, 64) : $urandom_range(0, 65535);
                send_beat(cmd, 8'($urandom), 16'(rounds));
            end
            else
            begin
                if (pick != 1)
                    send_beat(CMD_RESET, 8'($urandom), 16'($urandom));
                nbytes = ($urandom_range(0, 6) == 0) ? $urandom_range(60, 70)
                                                     : $urandom_range(0, 40);
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    rounds = $urandom_range(301, 2000);
                else if (pick < 6)
                    rounds = $urandom_range(41, 300);
                else
                    rounds = $urandom_range(0, 40);
                send_seeded_run(nbytes, rounds, $urandom_range(1, 40));
            end
        end
    endtask

    task automatic test_back_to_back();
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        send_beat(CMD_RESET, 8'h00, 16'h0000);
        send_seeded_run(16, 5, 40);
        send_seeded_run(3, 0, 20);
    endtask

    initial
    begin
        gen_clear();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_seed_overflow();
        test_output_stall();
        test_random(1000);
        test_back_to_back();

        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (4 * NW + 20) @(posedge clk);

        $display("%0d beats in, %0d words checked, %0d seed finishes", n_beats, n_words,
                 n_finish);
        $display("%0d words discarded, %0d seed bytes past the pool, %0d mismatches",
                 n_discarded, n_dropped, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> small_state_keystream_generator.f
sv/sskg_pkg.sv
sv/sskg_dp.sv
sv/sskg_ctrl.sv
sv/small_state_keystream_generator.sv
bench/tb_top.sv
